// ===== sv/f2p_pkg.sv =====
// ----------------------------------------------------------------------------
// f2p_pkg
// Shared constants and types for the float-to-PCM16 converter pipeline.
// ----------------------------------------------------------------------------
package f2p_pkg;

   localparam int unsigned FLOAT_WIDTH = 32;
   localparam int unsigned PCM_WIDTH   = 16;
   localparam logic [14:0] PCM_LIMIT   = 15'd32767;
   localparam logic [30:0] ONE_BITS    = 31'h3F80_0000;
   localparam logic [7:0]  EXP_ALL     = 8'hFF;

   // Product of a 24-bit significand and 32767 fits in 39 bits.
   localparam int unsigned PROD_WIDTH  = 39;

   typedef struct packed {
      logic nan;
      logic sat;
      logic neg;
      logic last;
   } ctrl_type;

endpackage

// ===== sv/float_to_pcm16_saturating.sv =====
// ----------------------------------------------------------------------------
// float_to_pcm16_saturating
// Converts single-precision audio samples to saturated signed 16-bit PCM.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one float32 bit pattern plus a last marker per
//   transfer. rsp_ channel returns the PCM sample, a NaN flag and the
//   copied last marker, one result transfer per request transfer, in order.
//   Both channels: transfer when valid is high and stall is low.
// Pipeline: three register stages (multiply stage, float rounding stage,
//   integer rounding stage); each request passes through them in that
//   order, and the rsp_ outputs come straight from the integer rounding
//   stage registers.
// Throughput: one sample per cycle while rsp_stall is low; the three-stage pipeline sets it.
// Stall: the output register holds when rsp_stall is high and it is full;
//   a stage ahead holds only if the next one holds and it is full, so
//   bubbles collapse; req_stall rises only when every stage holds a sample.
// Reset: synchronous, active high; clears all stage valid bits. No
//   payload state survives or matters.
// NaN inputs give 0 with the flag set; |x| >= 1.0 (and infinities)
//   saturate to +/-32767.
// ----------------------------------------------------------------------------
module float_to_pcm16_saturating (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_sample_bits,
   input  logic        req_last_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_pcm_sample,
   output logic        rsp_not_a_number,
   output logic        rsp_last_out
);
   logic                           s1_valid_ff, s2_valid_ff;
   f2p_pkg::ctrl_type              s1_ctrl_ff, s2_ctrl_ff;
   logic [f2p_pkg::PROD_WIDTH-1:0] s1_prod_ff;
   logic [7:0]                     s1_exp_ff;
   logic [24:0]                    s2_sig_ff;
   logic [9:0]                     s2_shift_ff;
   logic                           adv3, adv2, adv1;

   // Per-stage advance: a stage loads when its own register is free to move.
   assign adv3 = !rsp_valid || !rsp_stall;
   assign adv2 = adv3 || !s2_valid_ff;
   assign adv1 = adv2 || !s1_valid_ff;
   assign req_stall = !adv1;

   f2p_mult u_mult (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv1),
      .in_valid (req_valid),
      .in_bits  (req_sample_bits),
      .in_last  (req_last_in),
      .valid_ff (s1_valid_ff),
      .ctrl_ff  (s1_ctrl_ff),
      .prod_ff  (s1_prod_ff),
      .exp_ff   (s1_exp_ff)
   );

   f2p_round u_round (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv2),
      .in_valid (s1_valid_ff),
      .in_ctrl  (s1_ctrl_ff),
      .in_prod  (s1_prod_ff),
      .in_exp   (s1_exp_ff),
      .valid_ff (s2_valid_ff),
      .ctrl_ff  (s2_ctrl_ff),
      .sig_ff   (s2_sig_ff),
      .shift_ff (s2_shift_ff)
   );

   f2p_final u_final (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv3),
      .in_valid (s2_valid_ff),
      .in_ctrl  (s2_ctrl_ff),
      .in_sig   (s2_sig_ff),
      .in_shift (s2_shift_ff),
      .valid_ff (rsp_valid),
      .pcm_ff   (rsp_pcm_sample),
      .nan_ff   (rsp_not_a_number),
      .last_ff  (rsp_last_out)
   );
endmodule

// ===== sv/f2p_mult.sv =====
// ----------------------------------------------------------------------------
// f2p_mult
// Stage 1: unpack, classify and multiply the significand by 32767.
// ----------------------------------------------------------------------------
module f2p_mult (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  logic [31:0]                   in_bits,
   input  logic                          in_last,
   output logic                          valid_ff,
   output f2p_pkg::ctrl_type             ctrl_ff,
   output logic [f2p_pkg::PROD_WIDTH-1:0] prod_ff,
   output logic [7:0]                    exp_ff
);
   logic [30:0]            mag;
   logic [7:0]             ex;
   logic [23:0]            sig;
   f2p_pkg::ctrl_type      ctrl_in;

   assign mag = in_bits[30:0];
   assign ex  = mag[30:23];
   assign sig = (ex == 8'd0) ? {1'b0, mag[22:0]} : {1'b1, mag[22:0]};

   always_comb begin
      ctrl_in.nan  = (ex == f2p_pkg::EXP_ALL) && (mag[22:0] != 23'd0);
      ctrl_in.sat  = (mag >= f2p_pkg::ONE_BITS);
      ctrl_in.neg  = in_bits[31];
      ctrl_in.last = in_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
      if (adv) begin
         ctrl_ff <= ctrl_in;
         prod_ff <= 39'(sig) * 39'(f2p_pkg::PCM_LIMIT);
         exp_ff  <= (ex == 8'd0) ? 8'd1 : ex;
      end
   end
endmodule

// ===== sv/f2p_round.sv =====
// ----------------------------------------------------------------------------
// f2p_round
// Stage 2: round product to 24 significant bits, ties to even.
// ----------------------------------------------------------------------------
module f2p_round (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           adv,
   input  logic                           in_valid,
   input  f2p_pkg::ctrl_type              in_ctrl,
   input  logic [f2p_pkg::PROD_WIDTH-1:0] in_prod,
   input  logic [7:0]                     in_exp,
   output logic                           valid_ff,
   output f2p_pkg::ctrl_type              ctrl_ff,
   output logic [24:0]                    sig_ff,
   output logic [9:0]                     shift_ff
);
   // Leading one sits at bit 38 or lower; len = index + 1, k = len - 24.
   logic [5:0]  len;
   logic [3:0]  k;
   logic [38:0] q;
   logic [38:0] rem;
   logic [38:0] half;
   logic [24:0] qr;
   logic [9:0]  t;

   always_comb begin
      len = 6'd0;
      for (int i = 0; i < 39; i++) begin
         if (in_prod[i]) len = 6'(i + 1);
      end
      k    = (len > 6'd24) ? 4'(len - 6'd24) : 4'd0;
      q    = in_prod >> k;
      rem  = in_prod & ((39'd1 << k) - 39'd1);
      half = (k == 4'd0) ? 39'd0 : (39'd1 << (k - 4'd1));
      qr   = 25'(q);
      if (k != 4'd0 && (rem > half || (rem == half && q[0]))) qr = qr + 25'd1;
      // value = qr * 2^(exp - 150 + k); t = 150 - exp - k (positive for |x| < 1.0)
      t = 10'd150 - 10'(in_exp) - 10'(k);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
      if (adv) begin
         ctrl_ff  <= in_ctrl;
         sig_ff   <= qr;
         shift_ff <= t;
      end
   end
endmodule

// ===== sv/f2p_final.sv =====
// ----------------------------------------------------------------------------
// f2p_final
// Stage 3: round to integer (ties to even), saturate, apply sign.
// ----------------------------------------------------------------------------
module f2p_final (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  f2p_pkg::ctrl_type     in_ctrl,
   input  logic [24:0]           in_sig,
   input  logic [9:0]            in_shift,
   output logic                  valid_ff,
   output logic [15:0]           pcm_ff,
   output logic                  nan_ff,
   output logic                  last_ff
);
   logic [5:0]  t;
   logic [24:0] q;
   logic [24:0] rem;
   logic [24:0] half;
   logic [25:0] qr;
   logic [14:0] res;
   logic [15:0] pcm_in;

   always_comb begin
      // t >= 1 for |x| < 1.0; beyond 40 bits the value is below one half.
      t    = (in_shift > 10'd40) ? 6'd40 : 6'(in_shift);
      q    = (t > 6'd24) ? 25'd0 : (in_sig >> t);
      rem  = (t > 6'd24) ? in_sig : (in_sig & ((25'd1 << t) - 25'd1));
      half = (t > 6'd25) ? 25'h1FF_FFFF : (25'd1 << (t - 6'd1));
      qr   = {1'b0, q};
      if ((t <= 6'd25) && (rem > half || (rem == half && q[0]))) qr = qr + 26'd1;
      if (in_ctrl.nan)                       res = 15'd0;
      else if (in_ctrl.sat)                  res = f2p_pkg::PCM_LIMIT;
      else if (qr > 26'(f2p_pkg::PCM_LIMIT)) res = f2p_pkg::PCM_LIMIT;
      else                                   res = 15'(qr);
      pcm_in = in_ctrl.neg ? (16'd0 - {1'b0, res}) : {1'b0, res};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
      if (adv) begin
         pcm_ff  <= pcm_in;
         nan_ff  <= in_ctrl.nan;
         last_ff <= in_ctrl.last;
      end
   end
endmodule
